// File: hdl/ctc_pkg.sv
// Shared constants, command codes, status type and calendar helpers for the converter.
package ctc_pkg;

  localparam int unsigned YEAR_LIMIT = 9999;
  localparam int unsigned EPOCH_YEAR = 1601;

  // Days from 1601-01-01 to the first day of year YEAR_LIMIT + 1, and that instant in us
  localparam longint unsigned LIMIT_DAYS =
      64'(365 * (YEAR_LIMIT + 1 - EPOCH_YEAR)) +
      64'(YEAR_LIMIT / 4 - YEAR_LIMIT / 100 + YEAR_LIMIT / 400) - 64'd388;
  localparam longint unsigned LIMIT_US = LIMIT_DAYS * 64'd86400 * 64'd1000000;

  localparam int unsigned TS_W   = 58;
  localparam int unsigned YEAR_W = 14;
  localparam int unsigned MON_W  = 4;
  localparam int unsigned DAY_W  = 5;
  localparam int unsigned HOUR_W = 5;
  localparam int unsigned MIN_W  = 6;
  localparam int unsigned SEC_W  = 6;

  localparam int unsigned DCNT_W = 25;  // whole days since epoch
  localparam int unsigned SECS_W = 40;  // seconds since epoch, calendar direction
  localparam int unsigned DVS_W  = 20;  // widest divisor (one million)

  // Divider: radix-4096 long division, one digit per estimate/correct step pair
  localparam int unsigned DVD_W     = 60;               // dividend, five digits
  localparam int unsigned DIG_W     = 12;               // quotient digit
  localparam int unsigned NDIG      = DVD_W / DIG_W;
  localparam int unsigned DVAL_W    = DVS_W + DIG_W;    // remainder joined with a digit
  localparam int unsigned DSTEP_W   = 4;                // divider step counter
  localparam int unsigned RCP_SHIFT = 32;
  localparam int unsigned RCP_W     = 27;               // widest reciprocal (2^32 / 60)
  localparam int unsigned PROD_W    = DVAL_W + RCP_W;

  // Reciprocals rounded down: the digit estimate is at most one below the true digit
  localparam logic [RCP_W-1:0] RCP_US   = RCP_W'((64'd1 << RCP_SHIFT) / 64'd1000000);
  localparam logic [RCP_W-1:0] RCP_DAY  = RCP_W'((64'd1 << RCP_SHIFT) / 64'd86400);
  localparam logic [RCP_W-1:0] RCP_HOUR = RCP_W'((64'd1 << RCP_SHIFT) / 64'd3600);
  localparam logic [RCP_W-1:0] RCP_MIN  = RCP_W'((64'd1 << RCP_SHIFT) / 64'd60);

  typedef enum logic [4:0] {
    C_NOP, C_LOAD, C_CDAYS, C_CSECS, C_CLO, C_CMLO, C_CMHI, C_CSUM,
    C_TCHECK, C_DIV_US, C_DIV_DAY, C_DIV_HOUR, C_DIV_MIN, C_DIV_STEP, C_SAVE_MS,
    C_Y400, C_Y100, C_Y4, C_Y1, C_MON, C_DAYFIX, C_OUT
  } ctc_cmd_e;

  typedef struct packed {
    logic op;        // captured opcode
    logic ts_over;   // timestamp at or beyond the limit
    logic div_last;  // final divider step this cycle
    logic walk_go;   // walk step taken this cycle
    logic out_free;  // output register can take a result
  } ctc_sts_t;

  // Days before the start of month index i (0 = January)
  function automatic logic [8:0] days_before_month(input logic [3:0] i);
    logic [8:0] r;
    case (i)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd59;
      4'd3:    r = 9'd90;
      4'd4:    r = 9'd120;
      4'd5:    r = 9'd151;
      4'd6:    r = 9'd181;
      4'd7:    r = 9'd212;
      4'd8:    r = 9'd243;
      4'd9:    r = 9'd273;
      4'd10:   r = 9'd304;
      4'd11:   r = 9'd334;
      4'd12:   r = 9'd365;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // Floor of q / 25 by reciprocal multiply, exact for q below 4096
  function automatic logic [11:0] div25(input logic [11:0] q);
    logic [22:0] p;
    p = 23'(q) * 23'd1311;
    return 12'(p[22:15]);
  endfunction

  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    logic [11:0] q100;
    logic [11:0] q400;
    logic        c100;
    logic        c400;
    q100 = div25(y[13:2]);
    q400 = div25({2'b00, y[13:4]});
    c100 = (y[1:0] == 2'd0) && (y[13:2] == 12'(q100 * 12'd25));
    c400 = (y[3:0] == 4'd0) && ({2'b00, y[13:4]} == 12'(q400 * 12'd25));
    return (y[1:0] == 2'd0) && (!c100 || c400);
  endfunction

endpackage

// File: hdl/ctc_if.sv
// Valid/ready channel interfaces for calendar requests and results.
interface ctc_in_if;
  logic                   valid;
  logic                   ready;
  logic                   opcode;
  logic [13:0]            year;
  logic [3:0]             month;
  logic [4:0]             day;
  logic [4:0]             hour;
  logic [5:0]             minute;
  logic [5:0]             second;
  logic [57:0]            timestamp_us;

  modport source (output valid, opcode, year, month, day, hour, minute, second,
                  timestamp_us, input ready);
  modport sink   (input valid, opcode, year, month, day, hour, minute, second,
                  timestamp_us, output ready);
endinterface

interface ctc_out_if;
  logic        valid;
  logic        ready;
  logic [57:0] count_us;
  logic [13:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day;
  logic [4:0]  out_hour;
  logic [5:0]  out_minute;
  logic [5:0]  out_second;
  logic        range_error;

  modport source (output valid, count_us, out_year, out_month, out_day, out_hour,
                  out_minute, out_second, range_error, input ready);
  modport sink   (input valid, count_us, out_year, out_month, out_day, out_hour,
                  out_minute, out_second, range_error, output ready);
endinterface

// File: hdl/ctc_ctrl.sv
// Sequencing state machine: issues one datapath command per cycle.
module ctc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ctc_pkg::ctc_sts_t sts_i,
  output ctc_pkg::ctc_cmd_e cmd_o
);
  import ctc_pkg::*;

  typedef enum logic [17:0] {
    S_IDLE   = 18'h00001,
    S_DISP   = 18'h00002,
    S_CDAYS  = 18'h00004,
    S_CSECS  = 18'h00008,
    S_CLO    = 18'h00010,
    S_CMLO   = 18'h00020,
    S_CMHI   = 18'h00040,
    S_CSUM   = 18'h00080,
    S_TCHECK = 18'h00100,
    S_DSTART = 18'h00200,
    S_DWAIT  = 18'h00400,
    S_SAVE   = 18'h00800,
    S_Y400   = 18'h01000,
    S_Y100   = 18'h02000,
    S_Y4     = 18'h04000,
    S_Y1     = 18'h08000,
    S_MON    = 18'h10000,
    S_DONE   = 18'h20000
  } ctc_state_e;

  typedef enum logic [1:0] {
    P_US   = 2'd0,
    P_DAY  = 2'd1,
    P_HOUR = 2'd2,
    P_MIN  = 2'd3
  } ctc_phase_e;

  ctc_state_e state_q, state_d;
  ctc_phase_e dph_q, dph_d;

  always_comb begin
    state_d    = state_q;
    dph_d      = dph_q;
    cmd_o      = C_NOP;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o   = C_LOAD;
          state_d = S_DISP;
        end
      end
      S_DISP:  state_d = sts_i.op ? S_TCHECK : S_CDAYS;
      S_CDAYS: begin cmd_o = C_CDAYS; state_d = S_CSECS; end
      S_CSECS: begin cmd_o = C_CSECS; state_d = S_CLO; end
      S_CLO:   begin cmd_o = C_CLO;   state_d = S_CMLO; end
      S_CMLO:  begin cmd_o = C_CMLO;  state_d = S_CMHI; end
      S_CMHI:  begin cmd_o = C_CMHI;  state_d = S_CSUM; end
      S_CSUM:  begin cmd_o = C_CSUM;  state_d = S_DONE; end
      S_TCHECK: begin
        cmd_o   = C_TCHECK;
        dph_d   = P_US;
        state_d = sts_i.ts_over ? S_DONE : S_DSTART;
      end
      S_DSTART: begin
        case (dph_q)
          P_US:    cmd_o = C_DIV_US;
          P_DAY:   cmd_o = C_DIV_DAY;
          P_HOUR:  cmd_o = C_DIV_HOUR;
          P_MIN:   cmd_o = C_DIV_MIN;
          default: cmd_o = C_NOP;
        endcase
        state_d = S_DWAIT;
      end
      S_DWAIT: begin
        cmd_o = C_DIV_STEP;
        if (sts_i.div_last) begin
          if (dph_q == P_MIN) begin
            state_d = S_SAVE;
          end else begin
            dph_d   = ctc_phase_e'(dph_q + 2'd1);
            state_d = S_DSTART;
          end
        end
      end
      S_SAVE: begin cmd_o = C_SAVE_MS; state_d = S_Y400; end
      // each walk holds its state while a step is still taken
      S_Y400: begin cmd_o = C_Y400; if (!sts_i.walk_go) state_d = S_Y100; end
      S_Y100: begin cmd_o = C_Y100; if (!sts_i.walk_go) state_d = S_Y4; end
      S_Y4:   begin cmd_o = C_Y4;   if (!sts_i.walk_go) state_d = S_Y1; end
      S_Y1:   begin cmd_o = C_Y1;   if (!sts_i.walk_go) state_d = S_MON; end
      S_MON: begin
        cmd_o = C_MON;
        if (!sts_i.walk_go) state_d = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o   = C_OUT;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      dph_q   <= P_US;
    end else begin
      state_q <= state_d;
      dph_q   <= dph_d;
    end
  end

  property p_ready_only_idle;
    @(posedge clk_i) disable iff (!rst_ni) in_ready_o |-> state_q == S_IDLE;
  endproperty
  a_ready_only_idle: assert property (p_ready_only_idle)
    else $error("input taken outside idle");

  property p_out_after_accept;
    @(posedge clk_i) disable iff (!rst_ni) (cmd_o == C_OUT) |=> state_q == S_IDLE;
  endproperty
  a_out_after_accept: assert property (p_out_after_accept)
    else $error("result issued without return to idle");

  property p_div_phase;
    @(posedge clk_i) disable iff (!rst_ni)
      (state_q == S_SAVE) |-> dph_q == P_MIN;
  endproperty
  a_div_phase: assert property (p_div_phase)
    else $error("field split left early");

endmodule

// File: hdl/ctc_dp.sv
// Datapath: input capture, calendar arithmetic, shared divider, walks and result register.
module ctc_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctc_pkg::ctc_cmd_e cmd_i,
  output ctc_pkg::ctc_sts_t sts_o,
  input  logic              opcode_i,
  input  logic [13:0]       year_i,
  input  logic [3:0]        month_i,
  input  logic [4:0]        day_i,
  input  logic [4:0]        hour_i,
  input  logic [5:0]        minute_i,
  input  logic [5:0]        second_i,
  input  logic [57:0]       timestamp_us_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [57:0]       count_us_o,
  output logic [13:0]       out_year_o,
  output logic [3:0]        out_month_o,
  output logic [4:0]        out_day_o,
  output logic [4:0]        out_hour_o,
  output logic [5:0]        out_minute_o,
  output logic [5:0]        out_second_o,
  output logic              range_error_o
);
  import ctc_pkg::*;

  // captured request
  logic              op_q;
  logic [YEAR_W-1:0] yin_q;
  logic [MON_W-1:0]  min_mon_q;
  logic [DAY_W-1:0]  din_q;
  logic [HOUR_W-1:0] hin_q;
  logic [MIN_W-1:0]  mnin_q;
  logic [SEC_W-1:0]  sin_q;
  logic [TS_W-1:0]   ts_q;
  logic              err_q;

  // calendar to count
  logic [22:0]       dp1_q;
  logic [SECS_W-1:0] secs_q;
  logic [SECS_W-1:0] lo_q, hi_q;
  logic [TS_W-1:0]   us_q;

  // divider
  logic [DVD_W-1:0]   dvd_q;
  logic [DVS_W-1:0]   rem_q;
  logic [DVS_W-1:0]   dvs_q;
  logic [RCP_W-1:0]   rcp_q;
  logic [DIG_W-1:0]   qe_q;
  logic [DSTEP_W-1:0] step_q;

  // count to calendar
  logic [DCNT_W-1:0] d_q;
  logic [YEAR_W-1:0] yr_q;
  logic [MON_W-1:0]  mon_q;
  logic [1:0]        wcnt_q;
  logic [HOUR_W-1:0] hr_q;
  logic [MIN_W-1:0]  mn_q;
  logic [SEC_W-1:0]  sc_q;

  logic              outv_q;

  // combinational helpers
  logic [YEAR_W-1:0] xm1;
  logic [22:0]       lb, dp1_d;
  logic              bad_in;
  logic [SECS_W-1:0] hms;
  logic [60:0]       us_sum;
  logic [DVAL_W-1:0] dval;
  logic [PROD_W-1:0] qe_prod;
  logic [DVAL_W-1:0] qe_back;
  logic [DVAL_W-1:0] dres;
  logic              dfix;
  logic              leap_w;
  logic [DCNT_W-1:0] mon_next;
  logic [DCNT_W-1:0] mon_base;
  logic              walk_go;

  assign xm1 = yin_q - 14'd1;
  assign lb  = 23'(xm1[13:2]) - 23'(div25(xm1[13:2])) + 23'(div25({2'b00, xm1[13:4]}))
             - 23'd388;
  assign dp1_d = 23'(din_q) + 23'(days_before_month(min_mon_q - 4'd1))
               + 23'((is_leap(yin_q) && min_mon_q >= 4'd3) ? 1 : 0)
               + 23'd365 * 23'(yin_q - 14'(EPOCH_YEAR)) + lb;
  assign bad_in = (min_mon_q == 4'd0) || (min_mon_q > 4'd12) ||
                  (yin_q < 14'(EPOCH_YEAR)) || (yin_q > 14'(YEAR_LIMIT));
  assign hms = 40'(hin_q) * 40'd3600 + 40'(mnin_q) * 40'd60 + 40'(sin_q);
  assign us_sum = 61'(lo_q) + (61'(hi_q) << 20);

  // remainder below the divisor joined with the next digit stays below 2^32
  assign dval    = {rem_q, dvd_q[DVD_W-1 -: DIG_W]};
  assign qe_prod = PROD_W'(dval) * PROD_W'(rcp_q);
  assign qe_back = DVAL_W'(qe_q) * DVAL_W'(dvs_q);
  assign dres    = dval - qe_back;
  assign dfix    = dres >= DVAL_W'(dvs_q);

  assign leap_w   = is_leap(yr_q);
  assign mon_next = DCNT_W'(days_before_month(mon_q))
                  + DCNT_W'((mon_q >= 4'd2 && leap_w) ? 1 : 0);
  assign mon_base = DCNT_W'(days_before_month(mon_q - 4'd1))
                  + DCNT_W'((mon_q >= 4'd3 && leap_w) ? 1 : 0);

  always_comb begin
    case (cmd_i)
      C_Y400:  walk_go = d_q >= DCNT_W'(146097);
      C_Y100:  walk_go = (wcnt_q != 2'd3) && (d_q >= DCNT_W'(36524));
      C_Y4:    walk_go = d_q >= DCNT_W'(1461);
      C_Y1:    walk_go = (wcnt_q != 2'd3) && (d_q >= DCNT_W'(365));
      C_MON:   walk_go = (mon_q < 4'd12) && (d_q >= mon_next);
      default: walk_go = 1'b0;
    endcase
  end

  assign sts_o.op       = op_q;
  assign sts_o.ts_over  = 64'(ts_q) >= LIMIT_US;
  assign sts_o.div_last = (cmd_i == C_DIV_STEP) && (step_q == DSTEP_W'(2 * NDIG - 1));
  assign sts_o.walk_go  = walk_go;
  assign sts_o.out_free = !outv_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      C_LOAD: begin
        op_q      <= opcode_i;
        yin_q     <= year_i;
        min_mon_q <= month_i;
        din_q     <= day_i;
        hin_q     <= hour_i;
        mnin_q    <= minute_i;
        sin_q     <= second_i;
        ts_q      <= timestamp_us_i;
        err_q     <= 1'b0;
      end
      C_CDAYS: begin
        dp1_q <= dp1_d;
        err_q <= bad_in;
      end
      C_CSECS: secs_q <= 40'(dp1_q) * 40'd86400 + hms;
      C_CLO: begin
        // day counted from one: below one day means a time before the epoch
        if (secs_q < 40'd86400) err_q <= 1'b1;
        secs_q <= secs_q - 40'd86400;
      end
      C_CMLO: lo_q <= 40'(secs_q[19:0]) * 40'd1000000;
      C_CMHI: hi_q <= 40'(secs_q[39:20]) * 40'd1000000;
      C_CSUM: begin
        if (64'(us_sum) >= LIMIT_US) err_q <= 1'b1;
        us_q <= us_sum[TS_W-1:0];
      end
      C_TCHECK: err_q <= 64'(ts_q) >= LIMIT_US;
      C_DIV_US: begin
        dvd_q  <= DVD_W'(ts_q);
        dvs_q  <= DVS_W'(1000000);
        rcp_q  <= RCP_US;
        rem_q  <= '0;
        step_q <= '0;
      end
      C_DIV_DAY: begin
        dvs_q  <= DVS_W'(86400);
        rcp_q  <= RCP_DAY;
        rem_q  <= '0;
        step_q <= '0;
      end
      C_DIV_HOUR: begin
        d_q    <= dvd_q[DCNT_W-1:0];
        dvd_q  <= DVD_W'(rem_q);
        dvs_q  <= DVS_W'(3600);
        rcp_q  <= RCP_HOUR;
        rem_q  <= '0;
        step_q <= '0;
      end
      C_DIV_MIN: begin
        hr_q   <= dvd_q[HOUR_W-1:0];
        dvd_q  <= DVD_W'(rem_q);
        dvs_q  <= DVS_W'(60);
        rcp_q  <= RCP_MIN;
        rem_q  <= '0;
        step_q <= '0;
      end
      C_DIV_STEP: begin
        // even step: estimate the digit; odd step: correct it and shift it in
        if (!step_q[0]) begin
          qe_q <= qe_prod[RCP_SHIFT +: DIG_W];
        end else begin
          dvd_q <= {dvd_q[DVD_W-DIG_W-1:0], dfix ? qe_q + DIG_W'(1) : qe_q};
          rem_q <= dfix ? DVS_W'(dres - DVAL_W'(dvs_q)) : DVS_W'(dres);
        end
        step_q <= step_q + DSTEP_W'(1);
      end
      C_SAVE_MS: begin
        mn_q   <= dvd_q[MIN_W-1:0];
        sc_q   <= rem_q[SEC_W-1:0];
        yr_q   <= YEAR_W'(EPOCH_YEAR);
        mon_q  <= 4'd1;
        wcnt_q <= 2'd0;
      end
      C_Y400: begin
        wcnt_q <= 2'd0;
        if (walk_go) begin
          d_q  <= d_q - DCNT_W'(146097);
          yr_q <= yr_q + 14'd400;
        end
      end
      C_Y100: begin
        if (walk_go) begin
          d_q    <= d_q - DCNT_W'(36524);
          yr_q   <= yr_q + 14'd100;
          wcnt_q <= wcnt_q + 2'd1;
        end
      end
      C_Y4: begin
        wcnt_q <= 2'd0;
        if (walk_go) begin
          d_q  <= d_q - DCNT_W'(1461);
          yr_q <= yr_q + 14'd4;
        end
      end
      C_Y1: begin
        if (walk_go) begin
          d_q    <= d_q - DCNT_W'(365);
          yr_q   <= yr_q + 14'd1;
          wcnt_q <= wcnt_q + 2'd1;
        end
      end
      C_MON: begin
        if (walk_go) mon_q <= mon_q + 4'd1;
      end
      default: ;
    endcase
  end

  // result register
  logic [DAY_W-1:0] day_res;
  assign day_res = DAY_W'(d_q - mon_base + DCNT_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outv_q <= 1'b0;
    end else if (cmd_i == C_OUT) begin
      outv_q <= 1'b1;
    end else if (out_ready_i) begin
      outv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == C_OUT) begin
      range_error_o <= err_q;
      count_us_o    <= (!err_q && !op_q) ? us_q : '0;
      out_year_o    <= (!err_q && op_q) ? yr_q : '0;
      out_month_o   <= (!err_q && op_q) ? mon_q : '0;
      out_day_o     <= (!err_q && op_q) ? day_res : '0;
      out_hour_o    <= (!err_q && op_q) ? hr_q : '0;
      out_minute_o  <= (!err_q && op_q) ? mn_q : '0;
      out_second_o  <= (!err_q && op_q) ? sc_q : '0;
    end
  end

  assign out_valid_o = outv_q;

  property p_rem_below_divisor;
    @(posedge clk_i) disable iff (!rst_ni)
      (cmd_i == C_DIV_STEP) |-> rem_q < dvs_q;
  endproperty
  a_rem_below_divisor: assert property (p_rem_below_divisor)
    else $error("divider remainder out of range");

  property p_month_range;
    @(posedge clk_i) disable iff (!rst_ni)
      (cmd_i == C_OUT && op_q && !err_q) |-> (mon_q >= 4'd1 && mon_q <= 4'd12);
  endproperty
  a_month_range: assert property (p_month_range)
    else $error("month walk out of range");

  property p_out_loads;
    @(posedge clk_i) disable iff (!rst_ni) (cmd_i == C_OUT) |=> outv_q;
  endproperty
  a_out_loads: assert property (p_out_loads)
    else $error("result not presented");

endmodule

// File: hdl/calendar_timestamp_converter.sv
// Top level: calendar/microsecond-count converter, controller plus datapath.
// Converts between a Gregorian date and time and microseconds since 1601-01-01 00:00,
// one item at a time; the next item is taken while the previous result waits in the
// output register. Calendar to count forms the day count, the seconds since the epoch,
// a two-part multiply by one million and the sum of its parts. Count to calendar runs
// four passes of a radix-4096 reciprocal divider (for 10^6, 86400, 3600 and 60) followed
// by a year walk in 400, 100, 4 and 1 year strides and a month walk of up to eleven
// steps; a timestamp at or beyond the limit is flagged before the divider starts. A
// result that is not taken holds the next finished item in the controller.
// Out-of-range requests return range_error with every other field zero.
module calendar_timestamp_converter (
  input logic        clk_i,
  input logic        rst_ni,
  ctc_in_if.sink     in_i,
  ctc_out_if.source  out_o
);
  import ctc_pkg::*;

  ctc_cmd_e cmd;
  ctc_sts_t sts;
  logic     in_ready;

  assign in_i.ready = in_ready;

  ctc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ctc_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .opcode_i       (in_i.opcode),
    .year_i         (in_i.year),
    .month_i        (in_i.month),
    .day_i          (in_i.day),
    .hour_i         (in_i.hour),
    .minute_i       (in_i.minute),
    .second_i       (in_i.second),
    .timestamp_us_i (in_i.timestamp_us),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .count_us_o     (out_o.count_us),
    .out_year_o     (out_o.out_year),
    .out_month_o    (out_o.out_month),
    .out_day_o      (out_o.out_day),
    .out_hour_o     (out_o.out_hour),
    .out_minute_o   (out_o.out_minute),
    .out_second_o   (out_o.out_second),
    .range_error_o  (out_o.range_error)
  );

endmodule
